>>> hdl/dps_pkg.sv
// ----------------------------------------------------------------------------
// Difference pair search package
// Shared widths, the probe record that travels along the cell chain, and the
// controller state encoding.
// ----------------------------------------------------------------------------
package dps_pkg;

  // Default table capacity (number of cells in the chain).
  localparam int MAX_ITEMS_DEF = 256;

  // Q16.16 weight width and the exact sum width used for search keys.
  localparam int WEIGHT_W = 32;
  localparam int KEY_W    = WEIGHT_W + 1;

  // Width of the index fields in a result.
  localparam int INDEX_OUT_W = 8;

  // Probe record handed from cell to cell. The hit indices travel beside it,
  // since their width follows the chain depth.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key_plus;
    logic signed [KEY_W-1:0] key_minus;
    logic                    hit_plus;
    logic                    hit_minus;
  } probe_t;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

>>> hdl/dps_in_if.sv
// ----------------------------------------------------------------------------
// Weight request channel
// Valid/ready channel carrying one weight and its last mark.
// ----------------------------------------------------------------------------
interface dps_in_if;

  logic                                  valid;
  logic                                  ready;
  logic signed [dps_pkg::WEIGHT_W-1:0]   weight;
  logic                                  last;

  modport source (output valid, output weight, output last, input ready);
  modport sink   (input valid, input weight, input last, output ready);

endinterface

>>> hdl/dps_out_if.sv
// ----------------------------------------------------------------------------
// Result request channel
// Valid/ready channel carrying one search result.
// ----------------------------------------------------------------------------
interface dps_out_if;

  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [dps_pkg::INDEX_OUT_W-1:0]     earlier_index;
  logic [dps_pkg::INDEX_OUT_W-1:0]     later_index;
  logic                                overflow;

  modport source (output valid, output found, output earlier_index,
                  output later_index, output overflow, input ready);
  modport sink   (input valid, input found, input earlier_index,
                  input later_index, input overflow, output ready);

endinterface

>>> hdl/dps_cell.sv
// ----------------------------------------------------------------------------
// Difference pair search cell
// Holds one table entry, compares it against both keys of the passing probe
// and hands the probe, updated with any hit, to the next cell.
// ----------------------------------------------------------------------------
module dps_cell #(
  parameter int IDX_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dps_pkg::probe_t                     probe_in,
  input  logic [IDX_W-1:0]                    idx_plus_in,
  input  logic [IDX_W-1:0]                    idx_minus_in,
  output dps_pkg::probe_t                     probe_out,
  output logic [IDX_W-1:0]                    idx_plus_out,
  output logic [IDX_W-1:0]                    idx_minus_out,
  input  logic                                wr_sel,
  input  logic signed [dps_pkg::WEIGHT_W-1:0] wr_weight,
  input  logic                                clr
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [dps_pkg::WEIGHT_W-1:0] weight_r;
  logic                                valid_r;
  logic signed [dps_pkg::KEY_W-1:0]    weight_ext;
  logic                                match_plus;
  logic                                match_minus;
  dps_pkg::probe_t                     probe_r;
  dps_pkg::probe_t                     probe_nxt;
  logic [IDX_W-1:0]                    idx_plus_r;
  logic [IDX_W-1:0]                    idx_plus_nxt;
  logic [IDX_W-1:0]                    idx_minus_r;
  logic [IDX_W-1:0]                    idx_minus_nxt;

  // Compare the stored weight, sign-extended, with both keys.
  assign weight_ext  = {weight_r[dps_pkg::WEIGHT_W-1], weight_r};
  assign match_plus  = probe_in.valid && valid_r && (weight_ext == probe_in.key_plus);
  assign match_minus = probe_in.valid && valid_r && (weight_ext == probe_in.key_minus);

  // A hit here overrides earlier cells, so the highest index wins.
  always_comb begin
    probe_nxt     = probe_in;
    idx_plus_nxt  = idx_plus_in;
    idx_minus_nxt = idx_minus_in;
    if (match_plus) begin
      probe_nxt.hit_plus = 1'b1;
      idx_plus_nxt       = MY_IDX;
    end
    if (match_minus) begin
      probe_nxt.hit_minus = 1'b1;
      idx_minus_nxt       = MY_IDX;
    end
  end

  // Probe stage toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_nxt.valid;
    end
    probe_r.key_plus  <= probe_nxt.key_plus;
    probe_r.key_minus <= probe_nxt.key_minus;
    probe_r.hit_plus  <= probe_nxt.hit_plus;
    probe_r.hit_minus <= probe_nxt.hit_minus;
    idx_plus_r        <= idx_plus_nxt;
    idx_minus_r       <= idx_minus_nxt;
  end

  // Entry storage; a clear wins over a write.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= 1'b0;
    end else if (wr_sel) begin
      valid_r <= 1'b1;
    end
    if (wr_sel) begin
      weight_r <= wr_weight;
    end
  end

  assign probe_out     = probe_r;
  assign idx_plus_out  = idx_plus_r;
  assign idx_minus_out = idx_minus_r;

endmodule

>>> hdl/dps_chain.sv
// ----------------------------------------------------------------------------
// Difference pair search cell chain
// A row of MAX_ITEMS cells. A probe enters at cell 0 and moves one cell per
// cycle; the tail reports the latest matching index for each key.
// ----------------------------------------------------------------------------
module dps_chain #(
  parameter int MAX_ITEMS = dps_pkg::MAX_ITEMS_DEF,
  parameter int IDX_W     = $clog2(MAX_ITEMS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dps_pkg::probe_t                     probe_head,
  output dps_pkg::probe_t                     probe_tail,
  output logic [IDX_W-1:0]                    idx_plus_tail,
  output logic [IDX_W-1:0]                    idx_minus_tail,
  input  logic                                wr_en,
  input  logic [IDX_W-1:0]                    wr_addr,
  input  logic signed [dps_pkg::WEIGHT_W-1:0] wr_weight,
  input  logic                                clr
);

  dps_pkg::probe_t  link      [MAX_ITEMS+1];
  logic [IDX_W-1:0] idx_plus  [MAX_ITEMS+1];
  logic [IDX_W-1:0] idx_minus [MAX_ITEMS+1];

  assign link[0]      = probe_head;
  assign idx_plus[0]  = '0;
  assign idx_minus[0] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic sel;

    // Write decode for this cell.
    assign sel = wr_en && (wr_addr == IDX_W'(i));

    dps_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .probe_in      (link[i]),
      .idx_plus_in   (idx_plus[i]),
      .idx_minus_in  (idx_minus[i]),
      .probe_out     (link[i+1]),
      .idx_plus_out  (idx_plus[i+1]),
      .idx_minus_out (idx_minus[i+1]),
      .wr_sel        (sel),
      .wr_weight     (wr_weight),
      .clr           (clr)
    );
  end

  assign probe_tail     = link[MAX_ITEMS];
  assign idx_plus_tail  = idx_plus[MAX_ITEMS];
  assign idx_minus_tail = idx_minus[MAX_ITEMS];

endmodule

>>> hdl/difference_pair_search_top.sv
// ----------------------------------------------------------------------------
// Difference pair search top level
// Streams a set of Q16.16 weights through a chain of table cells and reports
// the first pair whose difference equals the configured target difference.
//
//   Channel   Direction  Handshake     Payload
//   in_bus    sink       valid/ready   weight, last
//   out_bus   source     valid/ready   found, earlier_index, later_index,
//                                      overflow
//   cfg_*     sink       cfg_we only   cfg_wdata (target difference)
//
// A searched item (positive weight, no pair yet in the set) moves from the
// idle state through the search state, where the probe walks the cell chain
// one cell per cycle, to the finish state; any other item skips the search.
// One item is in work at a time; a result waits in the output register while
// the next item is accepted, and the block holds the following result until
// out_bus takes it.
// Reset is synchronous and clears every table entry directly; no clearing pass.
// ----------------------------------------------------------------------------
module difference_pair_search_top #(
  parameter int MAX_ITEMS = dps_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dps_in_if.sink                              in_bus,
  dps_out_if.source                           out_bus,
  input  logic                                cfg_we,
  input  logic signed [dps_pkg::WEIGHT_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int OW    = dps_pkg::INDEX_OUT_W;

  dps_pkg::state_t                     state_r;
  dps_pkg::state_t                     state_nxt;
  logic signed [dps_pkg::WEIGHT_W-1:0] tdiff_r;
  logic signed [dps_pkg::WEIGHT_W-1:0] weight_r;
  logic                                last_r;
  logic                                searched_r;
  logic                                hit_r;
  logic [IDX_W-1:0]                    where_r;
  logic [CNT_W-1:0]                    count_r;
  logic                                pair_done_r;
  logic                                cap_r;

  logic                                out_valid_r;
  logic                                found_r;
  logic [OW-1:0]                       earlier_r;
  logic [OW-1:0]                       later_r;
  logic                                ovf_r;

  logic                                accept;
  logic                                w_pos;
  logic                                need_search;
  logic signed [dps_pkg::KEY_W-1:0]    w_ext;
  logic signed [dps_pkg::KEY_W-1:0]    d_ext;
  dps_pkg::probe_t                     probe_head;
  dps_pkg::probe_t                     probe_tail;
  logic [IDX_W-1:0]                    idx_plus_tail;
  logic [IDX_W-1:0]                    idx_minus_tail;

  logic                                beyond;
  logic                                cap_upd;
  logic                                emit_found;
  logic                                emit_nf;
  logic                                emit;
  logic                                out_free;
  logic                                finish_go;
  logic                                wr_en;
  logic                                clr;

  // Target difference register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdiff_r <= '0;
    end else if (cfg_we) begin
      tdiff_r <= cfg_wdata;
    end
  end

  // Request acceptance and search keys, formed exactly in 33 bits.
  assign in_bus.ready = (state_r == dps_pkg::ST_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign w_pos        = !in_bus.weight[dps_pkg::WEIGHT_W-1] && (|in_bus.weight);
  assign need_search  = !pair_done_r && w_pos;
  assign w_ext        = {in_bus.weight[dps_pkg::WEIGHT_W-1], in_bus.weight};
  assign d_ext        = {tdiff_r[dps_pkg::WEIGHT_W-1], tdiff_r};

  always_comb begin
    probe_head.valid     = accept && need_search;
    probe_head.key_plus  = w_ext + d_ext;
    probe_head.key_minus = w_ext - d_ext;
    probe_head.hit_plus  = 1'b0;
    probe_head.hit_minus = 1'b0;
  end

  dps_chain #(
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W)
  ) u_chain (
    .clk            (clk),
    .rst_n          (rst_n),
    .probe_head     (probe_head),
    .probe_tail     (probe_tail),
    .idx_plus_tail  (idx_plus_tail),
    .idx_minus_tail (idx_minus_tail),
    .wr_en          (wr_en),
    .wr_addr        (count_r[IDX_W-1:0]),
    .wr_weight      (weight_r),
    .clr            (clr)
  );

  // Set bookkeeping for the item being finished.
  assign beyond     = (count_r >= CNT_W'(MAX_ITEMS));
  assign cap_upd    = cap_r || (!pair_done_r && beyond);
  assign emit_found = !pair_done_r && hit_r;
  assign emit_nf    = last_r && !pair_done_r && !hit_r;
  assign emit       = emit_found || emit_nf;
  assign out_free   = !out_valid_r || out_bus.ready;
  assign finish_go  = (state_r == dps_pkg::ST_FINISH) && (!emit || out_free);
  assign wr_en      = finish_go && !last_r && !pair_done_r && searched_r &&
                      !hit_r && !beyond;
  assign clr        = finish_go && last_r;

  // Controller next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dps_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = need_search ? dps_pkg::ST_SEARCH : dps_pkg::ST_FINISH;
        end
      end
      dps_pkg::ST_SEARCH: begin
        if (probe_tail.valid) begin
          state_nxt = dps_pkg::ST_FINISH;
        end
      end
      dps_pkg::ST_FINISH: begin
        if (finish_go) begin
          state_nxt = dps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dps_pkg::ST_IDLE;
      end
    endcase
  end

  // Controller and set state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dps_pkg::ST_IDLE;
      count_r     <= '0;
      pair_done_r <= 1'b0;
      cap_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        count_r     <= '0;
        pair_done_r <= 1'b0;
        cap_r       <= 1'b0;
      end else if (finish_go && !pair_done_r) begin
        cap_r <= cap_upd;
        if (emit_found) begin
          pair_done_r <= 1'b1;
        end
        if (!beyond) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  // Item payload and search outcome.
  always_ff @(posedge clk) begin
    if (accept) begin
      weight_r   <= in_bus.weight;
      last_r     <= in_bus.last;
      searched_r <= need_search;
      hit_r      <= 1'b0;
    end else if ((state_r == dps_pkg::ST_SEARCH) && probe_tail.valid) begin
      hit_r   <= probe_tail.hit_plus || probe_tail.hit_minus;
      where_r <= probe_tail.hit_plus ? idx_plus_tail : idx_minus_tail;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
    if (finish_go && emit) begin
      found_r   <= emit_found;
      earlier_r <= emit_found ? OW'(where_r) : '0;
      later_r   <= emit_found ? OW'(count_r) : '0;
      ovf_r     <= cap_upd;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.found         = found_r;
  assign out_bus.earlier_index = earlier_r;
  assign out_bus.later_index   = later_r;
  assign out_bus.overflow      = ovf_r;

endmodule

>>> hdl/dps_checker.sv
// ----------------------------------------------------------------------------
// Difference pair search port checker
// Watches the top level's ports and flags behavior the design never shows.
// ----------------------------------------------------------------------------
module dps_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_found,
  input logic [dps_pkg::INDEX_OUT_W-1:0]     out_earlier_index,
  input logic [dps_pkg::INDEX_OUT_W-1:0]     out_later_index,
  input logic                                out_overflow
);

  // A result that waits keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
      $stable(out_earlier_index) && $stable(out_later_index) && $stable(out_overflow))
    else $error("result changed while stalled");

  // A not-found result carries zero indices.
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_earlier_index == '0 && out_later_index == '0)
    else $error("not-found result with nonzero index");

  // One item at a time: an accepted request is never followed at once by another.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted on consecutive cycles");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind difference_pair_search_top dps_checker u_dps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_found         (out_bus.found),
  .out_earlier_index (out_bus.earlier_index),
  .out_later_index   (out_bus.later_index),
  .out_overflow      (out_bus.overflow)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Difference pair search testbench
// Streams sets of Q16.16 weights into the block under random idling on both
// channels and checks every result against a built-in prediction of the
// pair search. A short directed part covers the corner cases. Random sets
// follow, mostly built from values a multiple of the target apart, so that
// pairs are common. The target difference changes between phases.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = dps_pkg::MAX_ITEMS_DEF;
  localparam int RUN_ITEMS  = 1550;
  localparam int PHASE_LEN  = 120;
  localparam int LONG_HOLD  = 3000;
  localparam int SETTLE     = CAP + 8;
  localparam int CYCLE_CAP  = 3000000;

  // Prediction of the pair search and the queue of pair reports it expects.
  class pair_scoreboard;
    typedef struct {
      logic       found;
      logic [7:0] earlier;
      logic [7:0] later;
      logic       overflow;
    } pair_report_t;

    logic signed [31:0] table_weight [CAP];
    bit                 table_valid [CAP];
    int unsigned        next_index;
    bit                 pair_done;
    bit                 cap_exceeded;
    logic signed [31:0] target;
    pair_report_t       reports [$];
    int                 mismatches;

    function new();
      clear_set();
      target     = '0;
      mismatches = 0;
    endfunction

    function void clear_set();
      foreach (table_valid[i]) table_valid[i] = 1'b0;
      next_index   = 0;
      pair_done    = 1'b0;
      cap_exceeded = 1'b0;
    endfunction

    // Highest valid entry whose weight equals the 33-bit key.
    function bit latest_match(input longint key, output int where);
      bit hit;
      hit   = 1'b0;
      where = 0;
      for (int i = 0; i < CAP; i++) begin
        if (table_valid[i] && longint'(table_weight[i]) == key) begin
          hit   = 1'b1;
          where = i;
        end
      end
      return hit;
    endfunction

    // Notes one accepted request; returns 1 unless the block ignores it.
    function bit note_weight(input logic signed [31:0] w, input bit last);
      longint       key_plus;
      longint       key_minus;
      int           where;
      int unsigned  idx;
      bit           hit;
      bit           beyond;
      bit           live;
      pair_report_t rep;
      live  = !pair_done;
      hit   = 1'b0;
      where = 0;
      if (!pair_done) begin
        idx    = next_index;
        beyond = idx >= CAP;
        if (beyond) cap_exceeded = 1'b1;
        if (w > 0) begin
          key_plus  = longint'(w) + longint'(target);
          key_minus = longint'(w) - longint'(target);
          hit = latest_match(key_plus, where);
          if (!hit) hit = latest_match(key_minus, where);
          if (hit) begin
            rep = '{1'b1, where[7:0], idx[7:0], cap_exceeded};
            reports.push_back(rep);
            pair_done = 1'b1;
          end else if (!beyond) begin
            table_weight[idx] = w;
            table_valid[idx]  = 1'b1;
          end
        end
        if (!beyond) next_index = idx + 1;
      end
      // The last request closes the set, reporting not found if needed.
      if (last) begin
        if (live && !hit) begin
          rep = '{1'b0, 8'd0, 8'd0, cap_exceeded};
          reports.push_back(rep);
        end
        clear_set();
      end
      return live;
    endfunction

    function void compare_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(input logic found, input logic [7:0] earlier,
                               input logic [7:0] later, input logic overflow);
      pair_report_t rep;
      if (reports.size() == 0) begin
        $error("result with no request pending: found=%0d earlier=%0d later=%0d",
               found, earlier, later);
        mismatches++;
      end else begin
        rep = reports.pop_front();
        compare_field("found", {7'd0, rep.found}, {7'd0, found});
        compare_field("earlier_index", rep.earlier, earlier);
        compare_field("later_index", rep.later, later);
        compare_field("overflow", {7'd0, rep.overflow}, {7'd0, overflow});
      end
    endfunction

    function int waiting();
      return reports.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic signed [31:0] cfg_wdata;

  dps_in_if  in_bus ();
  dps_out_if out_bus ();

  pair_scoreboard sb;
  bit  calm;
  int  hold_left;
  int  live_count;
  int  cycles;

  difference_pair_search_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL difference_pair_search_top");
      $finish;
    end
  end

  // Result side: check each accepted result, then pick the next ready.
  // A long hold-off is counted down here once the stimulus asks for it.
  always @(posedge clk) begin
    if (sb != null && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      sb.check_result(out_bus.found, out_bus.earlier_index,
                      out_bus.later_index, out_bus.overflow);
    end
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // Offers one weight request and waits for the block to take it.
  task automatic send_weight(input logic [31:0] w, input bit last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 18) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.weight <= w;
    in_bus.last   <= last;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    void'(sb.note_weight(w, last));
    live_count++;
  endtask

  // Stops offering, waits for every pending result and lets the block settle.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_target(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.target = v;
  endtask

  function automatic logic [31:0] nonpositive_weight();
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      default: return 32'h8000_0000 | $urandom();
    endcase
  endfunction

  // Weights mostly lie a small multiple of the target away from the set base.
  function automatic logic [31:0] pick_weight(input longint base);
    int     roll;
    int     k;
    longint v;
    roll = $urandom_range(99);
    if (roll < 10) return nonpositive_weight();
    if (roll < 30) return $urandom();
    k = int'($urandom_range(0, 7)) - 2;
    v = base + longint'(k) * longint'(sb.target);
    if (v >= 1 && v <= 64'h7FFF_FFFF) return v[31:0];
    return $urandom_range(1, 32'h7FFF_FFFF);
  endfunction

  function automatic longint pick_base();
    if ($urandom_range(1)) return longint'($urandom_range(1, 16'h7FFF)) << 16;
    return longint'($urandom_range(1, 32'h7FFF_FFFF));
  endfunction

  function automatic logic [31:0] pick_target(input int phase);
    longint v;
    case (phase)
      0: return 32'h8000_0000;
      1: return 32'h0000_0000;
      2: return 32'h7FFF_FFFF;
      default: begin
        case ($urandom_range(3))
          0, 1: begin
            v = (longint'($urandom_range(0, 16)) - 8) * 65536;
            return v[31:0];
          end
          2: begin
            v = longint'($urandom_range(0, 16'hFFFF));
            if ($urandom_range(1)) v = -v;
            return v[31:0];
          end
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  // A set longer than the table: cheap non-positive filler, a few stray
  // positive weights, then related weights around and beyond the capacity.
  task automatic send_long_set();
    int     len;
    longint base;
    logic [31:0] w;
    len  = $urandom_range(CAP + 2, CAP + 34);
    base = pick_base();
    for (int i = 0; i < len; i++) begin
      if (i < CAP - 8) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(1, 32'h7FFF_FFFF)
                                     : nonpositive_weight();
      end else begin
        w = pick_weight(base);
      end
      send_weight(w, i == len - 1);
    end
  endtask

  task automatic send_short_set();
    int     len;
    longint base;
    len  = $urandom_range(1, 10);
    base = pick_base();
    for (int i = 0; i < len; i++) send_weight(pick_weight(base), i == len - 1);
  endtask

  initial begin
    int phase;
    int set_no;
    int phase_start;
    sb               = new();
    calm             = 1'b0;
    hold_left        = 0;
    live_count       = 0;
    cycles           = 0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.weight    = '0;
    in_bus.last      = 1'b0;
    out_bus.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Target still at its reset value of zero: equal weights form a pair.
    send_weight(32'h0005_0000, 1'b0);
    send_weight(32'h0005_0000, 1'b1);
    drain_results();
    write_target(32'h0001_0000);

    // Skipped non-positive weights, a duplicate whose latest copy wins, and
    // requests after the pair that are ignored up to the last one.
    send_weight(32'hFFFD_0000, 1'b0);
    send_weight(32'h0000_0000, 1'b0);
    send_weight(32'h0004_0000, 1'b0);
    send_weight(32'h0004_0000, 1'b0);
    send_weight(32'h0003_0000, 1'b0);
    send_weight(32'h0007_0000, 1'b0);
    send_weight(32'h0009_0000, 1'b1);

    // Both keys match; the sum key is reported. The pair closes the set.
    send_weight(32'h0002_0000, 1'b0);
    send_weight(32'h0004_0000, 1'b0);
    send_weight(32'h0003_0000, 1'b1);

    // Sets that end without a pair, including single-request sets.
    send_weight(32'h0001_0000, 1'b0);
    send_weight(32'h000A_0000, 1'b1);
    send_weight(32'h7FFF_FFFF, 1'b1);
    send_weight(32'h8000_0000, 1'b1);

    // Target changed in the middle of a set.
    send_weight(32'h0006_0000, 1'b0);
    drain_results();
    write_target(32'hFFFE_0000);
    send_weight(32'h0008_0000, 1'b0);
    send_weight(32'h0001_0000, 1'b1);

    // Extreme targets: the 33-bit keys must not wrap.
    drain_results();
    write_target(32'h7FFF_FFFE);
    send_weight(32'h0000_0001, 1'b0);
    send_weight(32'h7FFF_FFFF, 1'b1);
    drain_results();
    write_target(32'h7FFF_FFFF);
    send_weight(32'h7FFF_FFFF, 1'b0);
    send_weight(32'h0000_0001, 1'b1);

    // Random phases, each under its own target difference.
    live_count = 0;
    phase      = 0;
    set_no     = 0;
    while (live_count < RUN_ITEMS) begin
      drain_results();
      write_target(pick_target(phase));
      calm        = (phase == 3);
      phase_start = live_count;
      while (live_count - phase_start < PHASE_LEN && live_count < RUN_ITEMS) begin
        if (set_no == 40) hold_left = LONG_HOLD;
        if (set_no == 5 || set_no == 150) send_long_set();
        else send_short_set();
        set_no++;
      end
      phase++;
    end
    calm = 1'b0;

    drain_results();
    if (sb.mismatches == 0) begin
      $display("PASS difference_pair_search_top");
    end else begin
      $display("FAIL difference_pair_search_top");
    end
    $finish;
  end

endmodule
